FILE: sv/assert_macros.svh
// Assertion helpers used by the copy engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define LZD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LZD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lzd_pkg.sv
package lzd_pkg;

    // History window, fixed by the 12-bit distance field of the format.
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // Token decoding constants.
    localparam int           FLAG_MSB        = 7;
    localparam logic [3:0]   TOKENS_PER_FLAG = 4'd8;
    localparam logic [4:0]   LEN_BIAS        = 5'd3;
    localparam logic [12:0]  DIST_BIAS       = 13'd1;

    // Parser phase of the compressed stream.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_FLAGS,
        PH_TOKEN,
        PH_REF2,
        PH_WAIT,
        PH_DONE
    } t_phase;

    // Copy engine sequencer state.
    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_EMIT
    } t_eng_state;

    // Command from the parser to the copy engine.
    typedef struct packed {
        logic        clear;
        logic        start;
        logic        is_ref;
        logic [7:0]  lit_byte;
        logic [4:0]  len;
        logic [12:0] distance;
    } t_copy_cmd;

endpackage

FILE: sv/lzd_in_if.sv
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic       stream_start;
    logic [7:0] in_byte;

    modport source (output valid, output stream_start, output in_byte, input ready);
    modport sink   (input valid, input stream_start, input in_byte, output ready);
endinterface

FILE: sv/lzd_out_if.sv
interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;
    logic       bad_ref;

    modport source (output valid, output out_byte, output run_end, output stream_end,
                    output bad_ref, input ready);
    modport sink   (input valid, input out_byte, input run_end, input stream_end,
                    input bad_ref, output ready);
endinterface

FILE: sv/lzd_copy.sv
`include "assert_macros.svh"

module lzd_copy
    import lzd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_copy_cmd        i_cmd,
    input  logic [23:0]      i_total,
    output logic             o_idle,
    output logic             o_reached,
    lzd_out_if.source        o_out
);

    // History memory, one write and one registered read per cycle.
    logic [7:0] r_hist [HIST_DEPTH];

    t_eng_state         r_st, n_st;
    logic               r_lit;
    logic [7:0]         r_byte;
    logic [4:0]         r_rem;
    logic [12:0]        r_dist;
    logic [HIST_AW-1:0] r_ptr;
    logic [23:0]        r_cnt;
    logic [7:0]         r_rdata;

    logic               r_ov;
    logic [7:0]         r_ob;
    logic               r_ore;
    logic               r_ose;
    logic               r_obad;

    logic               out_free;
    logic               emit_now;
    logic [7:0]         emit_val;
    logic               emit_bad;
    logic               emit_last;
    logic [23:0]        cnt_inc;
    logic               ref_bad;
    logic [HIST_AW-1:0] rd_addr;

    assign out_free = !r_ov || o_out.ready;
    assign cnt_inc  = r_cnt + 24'd1;
    assign ref_bad  = {11'd0, r_dist} > r_cnt;
    assign rd_addr  = r_ptr - r_dist[HIST_AW-1:0];

    // Byte selection for the shared emit path: a literal or one copied byte.
    always_comb begin
        emit_now  = 1'b0;
        emit_val  = 8'd0;
        emit_bad  = 1'b0;
        emit_last = 1'b0;
        unique case (r_st)
            E_IDLE: begin
                emit_now  = i_cmd.start && !i_cmd.clear && !i_cmd.is_ref && out_free;
                emit_val  = i_cmd.lit_byte;
                emit_last = 1'b1;
            end
            E_EMIT: begin
                emit_now = out_free;
                if (r_lit) begin
                    emit_val  = r_byte;
                    emit_last = 1'b1;
                end else begin
                    emit_bad  = ref_bad;
                    emit_val  = ref_bad ? 8'd0 : r_rdata;
                    emit_last = (r_rem == 5'd1) || (cnt_inc == i_total);
                end
            end
            default: begin
                emit_now = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            E_IDLE: begin
                if (i_cmd.start && !i_cmd.clear) begin
                    if (i_cmd.is_ref) begin
                        n_st = E_READ;
                    end else if (!out_free) begin
                        n_st = E_EMIT;
                    end
                end
            end
            E_READ: begin
                n_st = E_EMIT;
            end
            E_EMIT: begin
                if (out_free) begin
                    n_st = emit_last ? E_IDLE : E_READ;
                end
            end
            default: begin
                n_st = E_IDLE;
            end
        endcase
    end

    // Sequencer and stream counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= E_IDLE;
            r_ptr <= '0;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (i_cmd.clear) begin
                r_ptr <= '0;
                r_cnt <= '0;
            end else if (emit_now) begin
                r_ptr <= r_ptr + 1'b1;
                r_cnt <= cnt_inc;
            end
        end
    end

    // Command capture and the copy length count.
    always_ff @(posedge i_clk) begin
        if (r_st == E_IDLE && i_cmd.start) begin
            r_lit  <= !i_cmd.is_ref;
            r_byte <= i_cmd.lit_byte;
            r_rem  <= i_cmd.len;
            r_dist <= i_cmd.distance;
        end else if (r_st == E_EMIT && emit_now) begin
            r_rem <= r_rem - 5'd1;
        end
    end

    // History write on every emitted byte; read issued from the read step.
    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_hist[r_ptr] <= emit_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == E_READ) begin
            r_rdata <= r_hist[rd_addr];
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_now) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_ob   <= emit_val;
            r_ore  <= emit_last;
            r_ose  <= (cnt_inc == i_total);
            r_obad <= emit_bad;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.run_end    = r_ore;
    assign o_out.stream_end = r_ose;
    assign o_out.bad_ref    = r_obad;

    assign o_idle    = (r_st == E_IDLE);
    assign o_reached = (r_cnt >= i_total);

    // A copied byte is only emitted after its history read.
    `LZD_ASSERT(a_read_before_emit, i_clk, i_rst_n, (r_st == E_EMIT && !r_lit) |-> ($past(r_st) == E_READ || $past(r_st) == E_EMIT), "copy emit without a history read")
    // The engine never runs past the declared size.
    `LZD_ASSERT(a_count_bound, i_clk, i_rst_n, (r_st != E_IDLE) |-> (r_cnt < i_total), "copy engine busy at or beyond the declared size")
    // A flagged reference always delivers a zero byte.
    `LZD_ASSERT(a_bad_is_zero, i_clk, i_rst_n, (r_ov && r_obad) |-> (r_ob == 8'd0), "bad reference with a nonzero byte")

endmodule

FILE: sv/lz77_stream_decompressor_top.sv
// Channel   Direction  Interface   Payload
// i_in      in         lzd_in_if   stream_start, in_byte
// o_out     out        lzd_out_if  out_byte, run_end, stream_end, bad_ref
//
// Header, flag and first reference bytes load parser registers; a literal goes to the
// engine. The second reference byte starts a copy of N bytes (N up to 18): each copied byte
// is one registered history read followed by one emit.
// Reset is synchronous and active low; the history memory needs no clearing pass.
// A stalled output holds the engine, and input stays blocked until the item is done.

module lz77_stream_decompressor_top
    import lzd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzd_in_if.sink     i_in,
    lzd_out_if.source  o_out
);

    t_phase      r_phase, n_phase;
    logic [23:0] r_total;
    logic [7:0]  r_flags;
    logic [3:0]  r_count;
    logic [7:0]  r_ref_hi;

    logic        accept;
    logic        eng_idle;
    logic        eng_reached;
    t_copy_cmd   cmd;

    assign accept = i_in.valid && i_in.ready;

    // Handshake and engine command.
    always_comb begin
        i_in.ready = (r_phase != PH_WAIT);
        cmd        = '0;
        if (accept) begin
            if (i_in.stream_start) begin
                cmd.clear = 1'b1;
            end else if (r_phase == PH_TOKEN && !r_flags[FLAG_MSB]) begin
                cmd.start    = 1'b1;
                cmd.lit_byte = i_in.in_byte;
            end else if (r_phase == PH_REF2) begin
                cmd.start    = 1'b1;
                cmd.is_ref   = 1'b1;
                cmd.len      = {1'b0, r_ref_hi[7:4]} + LEN_BIAS;
                cmd.distance = {1'b0, r_ref_hi[3:0], i_in.in_byte} + DIST_BIAS;
            end
        end
    end

    // Parser next phase.
    always_comb begin
        n_phase = r_phase;
        priority if (accept && i_in.stream_start) begin
            n_phase = PH_HDR1;
        end else if (accept) begin
            unique case (r_phase)
                PH_HDR1:  n_phase = PH_HDR2;
                PH_HDR2:  n_phase = PH_HDR3;
                PH_HDR3:  n_phase = ({i_in.in_byte, r_total[15:0]} == 24'd0) ? PH_DONE
                                                                             : PH_FLAGS;
                PH_FLAGS: n_phase = PH_TOKEN;
                PH_TOKEN: n_phase = r_flags[FLAG_MSB] ? PH_REF2 : PH_WAIT;
                PH_REF2:  n_phase = PH_WAIT;
                default:  n_phase = r_phase;
            endcase
        end else if (r_phase == PH_WAIT && eng_idle) begin
            if (eng_reached) begin
                n_phase = PH_DONE;
            end else if (r_count == 4'd0) begin
                n_phase = PH_FLAGS;
            end else begin
                n_phase = PH_TOKEN;
            end
        end else begin
            n_phase = r_phase;
        end
    end

    // Header, flag and token registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_total  <= '0;
            r_flags  <= '0;
            r_count  <= '0;
            r_ref_hi <= '0;
        end else begin
            r_phase <= n_phase;
            if (accept) begin
                if (i_in.stream_start) begin
                    r_total  <= '0;
                    r_flags  <= '0;
                    r_count  <= '0;
                    r_ref_hi <= '0;
                end else begin
                    unique case (r_phase)
                        PH_HDR1:  r_total        <= {16'd0, i_in.in_byte};
                        PH_HDR2:  r_total[15:8]  <= i_in.in_byte;
                        PH_HDR3:  r_total[23:16] <= i_in.in_byte;
                        PH_FLAGS: begin
                            r_flags <= i_in.in_byte;
                            r_count <= TOKENS_PER_FLAG;
                        end
                        PH_TOKEN: begin
                            if (r_flags[FLAG_MSB]) begin
                                r_ref_hi <= i_in.in_byte;
                            end else begin
                                r_flags <= {r_flags[6:0], 1'b0};
                                if (r_count != 4'd0) begin
                                    r_count <= r_count - 4'd1;
                                end
                            end
                        end
                        PH_REF2: begin
                            r_flags <= {r_flags[6:0], 1'b0};
                            if (r_count != 4'd0) begin
                                r_count <= r_count - 4'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    lzd_copy u_copy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_total   (r_total),
        .o_idle    (eng_idle),
        .o_reached (eng_reached),
        .o_out     (o_out)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// One decoded byte as it leaves the block.
typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       stream_end;
    logic       bad_ref;
} t_decoded;

// Tracks the decoder state and holds the decoded bytes still owed by the block.
class lz77_decode_predictor;
    logic [7:0]          history [lzd_pkg::HIST_DEPTH];
    logic [11:0]         hist_ptr;
    logic [23:0]         total_size;
    logic [23:0]         bytes_written;
    lzd_pkg::t_phase     phase;
    logic [7:0]          token_flags;
    logic [3:0]          token_count;
    logic [7:0]          ref_high;
    t_decoded            owed_bytes[$];
    int unsigned         inputs;
    int unsigned         streams;
    int unsigned         checked;
    int unsigned         bad_refs;
    int unsigned         stream_ends;
    int unsigned         mismatches;

    function new();
        foreach (history[k]) history[k] = 8'h00;
        hist_ptr      = '0;
        total_size    = '0;
        bytes_written = '0;
        phase         = lzd_pkg::PH_IDLE;
        token_flags   = '0;
        token_count   = '0;
        ref_high      = '0;
        inputs        = 0;
        streams       = 0;
        checked       = 0;
        bad_refs      = 0;
        stream_ends   = 0;
        mismatches    = 0;
    endfunction

    function int unsigned pending();
        return owed_bytes.size();
    endfunction

    // Writes one byte into the history and queues it as an expected output.
    function void emit(logic [7:0] v, logic bad);
        t_decoded d;
        history[hist_ptr] = v;
        hist_ptr      = hist_ptr + 12'd1;
        bytes_written = bytes_written + 24'd1;
        d.value      = v;
        d.run_end    = 1'b0;
        d.stream_end = (bytes_written == total_size);
        d.bad_ref    = bad;
        if (bad) bad_refs++;
        if (d.stream_end) stream_ends++;
        owed_bytes.push_back(d);
    endfunction

    // Moves to the next token, a new flag byte, or the end of the stream.
    function void next_token();
        token_flags = token_flags << 1;
        if (token_count > 0) token_count = token_count - 4'd1;
        if (bytes_written >= total_size) phase = lzd_pkg::PH_DONE;
        else if (token_count == 0) phase = lzd_pkg::PH_FLAGS;
        else phase = lzd_pkg::PH_TOKEN;
    endfunction

    // Called for every accepted input transfer.
    function void take_compressed(logic start, logic [7:0] b);
        logic [4:0]  len;
        logic [12:0] distance;
        logic [11:0] src;
        int unsigned n;
        int unsigned i;
        inputs++;
        n = 0;
        // A stream start abandons whatever was in progress.
        if (start) begin
            total_size    = '0;
            bytes_written = '0;
            hist_ptr      = '0;
            token_flags   = '0;
            token_count   = '0;
            ref_high      = '0;
            phase         = lzd_pkg::PH_HDR1;
            streams++;
            return;
        end
        case (phase)
            lzd_pkg::PH_HDR1: begin
                total_size = {16'h0000, b};
                phase = lzd_pkg::PH_HDR2;
            end
            lzd_pkg::PH_HDR2: begin
                total_size[15:8] = b;
                phase = lzd_pkg::PH_HDR3;
            end
            lzd_pkg::PH_HDR3: begin
                total_size[23:16] = b;
                phase = (total_size == 0) ? lzd_pkg::PH_DONE : lzd_pkg::PH_FLAGS;
            end
            lzd_pkg::PH_FLAGS: begin
                token_flags = b;
                token_count = lzd_pkg::TOKENS_PER_FLAG;
                phase = lzd_pkg::PH_TOKEN;
            end
            lzd_pkg::PH_TOKEN: begin
                if (token_flags[lzd_pkg::FLAG_MSB]) begin
                    ref_high = b;
                    phase = lzd_pkg::PH_REF2;
                end else begin
                    emit(b, 1'b0);
                    n = 1;
                    next_token();
                end
            end
            lzd_pkg::PH_REF2: begin
                // Copy from the history; sources before the stream start read as zero.
                len      = {1'b0, ref_high[7:4]} + lzd_pkg::LEN_BIAS;
                distance = {1'b0, ref_high[3:0], b} + lzd_pkg::DIST_BIAS;
                for (i = 0; i < len && bytes_written < total_size; i++) begin
                    src = hist_ptr - distance[11:0];
                    if (distance > bytes_written) emit(8'h00, 1'b1);
                    else emit(history[src], 1'b0);
                    n++;
                end
                next_token();
            end
            default: begin
            end
        endcase
        if (n > 0) owed_bytes[owed_bytes.size() - 1].run_end = 1'b1;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
            mismatches++;
        end
    endfunction

    // Called for every accepted output transfer.
    function void check_decoded(logic [7:0] value, logic run_end, logic stream_end,
                                logic bad_ref);
        t_decoded want;
        if (owed_bytes.size() == 0) begin
            $error("out_byte 0x%02h arrived with no decoded byte pending", value);
            mismatches++;
            return;
        end
        want = owed_bytes.pop_front();
        checked++;
        compare_field("out_byte", want.value, value);
        compare_field("run_end", {7'd0, want.run_end}, {7'd0, run_end});
        compare_field("stream_end", {7'd0, want.stream_end}, {7'd0, stream_end});
        compare_field("bad_ref", {7'd0, want.bad_ref}, {7'd0, bad_ref});
    endfunction
endclass

module testbench;
    import lzd_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 360;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned TAIL_CYCLES  = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_req = 1'b0;
    int unsigned burst_left = 0;

    lz77_decode_predictor predictor;

    lzd_in_if  in_if ();
    lzd_out_if out_if ();

    lz77_stream_decompressor_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one compressed byte and waits for its transfer; bursts end in a gap.
    task automatic send_item(input logic start, input logic [7:0] b);
        in_if.valid        <= 1'b1;
        in_if.stream_start <= start;
        in_if.in_byte      <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predictor.take_compressed(start, b);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stops offering input until every owed byte has come out.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (predictor.pending() > 0) @(posedge i_clk);
    endtask

    task automatic send_header(input logic [7:0] type_byte, input logic [23:0] size);
        send_item(1'b1, type_byte);
        send_item(1'b0, size[7:0]);
        send_item(1'b0, size[15:8]);
        send_item(1'b0, size[23:16]);
    endtask

    // Sends a well-formed stream; a nonzero cut_after abandons it after that many tokens.
    task automatic send_stream(input logic [23:0] size, input int unsigned cut_after);
        int unsigned produced;
        int unsigned tokens;
        int unsigned len;
        int unsigned distance;
        int          k;
        logic [7:0]  flags;
        logic [11:0] dist_m1;
        logic [3:0]  len_m3;
        produced = 0;
        tokens   = 0;
        send_header(8'($urandom_range(0, 255)), size);
        while (produced < size && (cut_after == 0 || tokens < cut_after)) begin
            flags = 8'($urandom_range(0, 255));
            send_item(1'b0, flags);
            for (k = 7; k >= 0 && produced < size && (cut_after == 0 || tokens < cut_after);
                 k--) begin
                if (flags[k]) begin
                    // Mostly references that land inside the bytes already written.
                    len = $urandom_range(3, 18);
                    if (produced > 0 && $urandom_range(0, 9) != 0)
                        distance = $urandom_range(1, (produced > 4096) ? 4096 : produced);
                    else
                        distance = $urandom_range(1, 4096);
                    dist_m1 = 12'(distance - 1);
                    len_m3  = 4'(len - 3);
                    send_item(1'b0, {len_m3, dist_m1[11:8]});
                    send_item(1'b0, dist_m1[7:0]);
                    produced += len;
                end else begin
                    send_item(1'b0, 8'($urandom_range(0, 255)));
                    produced++;
                end
                tokens++;
            end
        end
    endtask

    // Receiver: segments of steady, random or periodic ready, plus requested hold-offs.
    initial begin : receiver
        int unsigned seg_left;
        int unsigned mode;
        int unsigned period;
        int unsigned tick;
        int unsigned hold_left;
        seg_left  = 0;
        mode      = 0;
        period    = 2;
        tick      = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                period   = $urandom_range(2, 4);
                seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 1) == 1);
                    default: out_if.ready <= (tick % period == 0);
                endcase
            end
            @(posedge i_clk);
        end
    end

    // Every output transfer is checked against the oldest owed byte.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            predictor.check_decoded(out_if.out_byte, out_if.run_end, out_if.stream_end,
                                    out_if.bad_ref);
    end

    // Stimulus: directed streams first, then random streams, noise and aborted streams.
    initial begin : stimulus
        int unsigned directed_items;
        int unsigned stream_idx;
        int unsigned pick;
        predictor = new();
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.stream_start <= 1'b0;
        in_if.in_byte      <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 12);

        // Bytes before any stream are dropped.
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        // Literal, then a longest reference at distance one cut short by the size,
        // then a trailing byte after the stream is done.
        send_header(8'h10, 24'd6);
        send_item(1'b0, 8'h40);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hF0);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h5A);
        wait_drained();
        // A zero-size stream ends at its header.
        send_header(8'h00, 24'd0);
        send_item(1'b0, 8'hAB);
        // Largest size, a reference from before the start, a zero literal; the next
        // stream start abandons this one.
        send_header(8'hFF, 24'hFFFFFF);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h0F);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        directed_items = predictor.inputs;

        stream_idx = 0;
        while (predictor.inputs < directed_items + RANDOM_ITEMS) begin
            // Long receiver hold-off while the sender keeps offering bytes.
            if (stream_idx == 3 || stream_idx == 9) hold_req = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_stream(24'($urandom_range(1, 100)), 0);
                repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom_range(0, 255)));
            end else if (pick < 9) begin
                send_stream(24'($urandom_range(1, 24'hFFFFFF)), $urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
            end
            if (stream_idx == 5 || $urandom_range(0, 3) == 0) wait_drained();
            stream_idx++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d input transfers over %0d streams and checked %0d output",
                 predictor.inputs, predictor.streams, predictor.checked);
        $display("transfers, %0d of them bad references and %0d stream ends.",
                 predictor.bad_refs, predictor.stream_ends);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_000_000;
        $display("Timed out with %0d decoded bytes outstanding", predictor.pending());
        $display("Mismatches found");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/lzd_pkg.sv
sv/lzd_in_if.sv
sv/lzd_out_if.sv
sv/lzd_copy.sv
sv/lz77_stream_decompressor_top.sv
test/testbench.sv
